FILE: src/ljc_pkg.sv
// Package for the line junction classifier: road and phase codes, shared
// structs and small helper functions.
// No dependencies; every other file of the block imports it.
`default_nettype none

package ljc_pkg;

  // Road type codes
  localparam logic [3:0] ROAD_UNKNOWN  = 4'd0;
  localparam logic [3:0] ROAD_LOST     = 4'd1;
  localparam logic [3:0] ROAD_STRAIGHT = 4'd2;
  localparam logic [3:0] ROAD_LBRANCH  = 4'd3;
  localparam logic [3:0] ROAD_RBRANCH  = 4'd4;
  localparam logic [3:0] ROAD_T        = 4'd5;
  localparam logic [3:0] ROAD_CROSS    = 4'd6;
  localparam logic [3:0] ROAD_LCORNER  = 4'd7;
  localparam logic [3:0] ROAD_RCORNER  = 4'd8;

  // Phase codes
  localparam logic [1:0] PH_NORMAL    = 2'd0;
  localparam logic [1:0] PH_OBSERVING = 2'd1;
  localparam logic [1:0] PH_LATCHED   = 2'd2;

  // Path bits
  localparam int unsigned P_LEFT  = 0;
  localparam int unsigned P_FWD   = 1;
  localparam int unsigned P_RIGHT = 2;

  // Configuration register indexes
  localparam logic [2:0] REG_LEFT_MASK   = 3'd0;
  localparam logic [2:0] REG_CENTER_MASK = 3'd1;
  localparam logic [2:0] REG_RIGHT_MASK  = 3'd2;
  localparam logic [2:0] REG_CONFIRM     = 3'd3;
  localparam logic [2:0] REG_EXIT        = 3'd4;
  localparam logic [2:0] REG_REARM       = 3'd5;
  localparam logic [2:0] REG_OBSERVE     = 3'd6;

  // Stream widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 144;

  typedef struct packed {
    logic [7:0] left_group;
    logic [7:0] center_group;
    logic [7:0] right_group;
    logic [7:0] confirm_count;
    logic [7:0] exit_count;
    logic [7:0] rearm_limit;
    logic [7:0] observe_limit;
  } cfg_t;

  // Decoded view of one frame
  typedef struct packed {
    logic [7:0] mask;
    logic [2:0] paths;
    logic [3:0] ones;
  } frame_info_t;

  typedef struct packed {
    logic [3:0]  road_type;
    logic [1:0]  phase_now;
    logic        event_published;
    logic [31:0] event_number;
    logic [3:0]  event_type;
    logic [2:0]  event_paths;
    logic [9:0]  event_confidence;
    logic [7:0]  entry_sensor_mask;
    logic [7:0]  peak_sensor_mask;
    logic [7:0]  exit_sensor_mask;
    logic [31:0] first_frame_number;
    logic [31:0] last_frame_number;
  } result_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [3:0] kind_of(input logic [2:0] p);
    logic l;
    logic f;
    logic r;
    l = p[P_LEFT];
    f = p[P_FWD];
    r = p[P_RIGHT];
    if (l && f && r)  kind_of = ROAD_CROSS;
    else if (l && r)  kind_of = ROAD_T;
    else if (l && f)  kind_of = ROAD_LBRANCH;
    else if (r && f)  kind_of = ROAD_RBRANCH;
    else if (l)       kind_of = ROAD_LCORNER;
    else if (r)       kind_of = ROAD_RCORNER;
    else if (f)       kind_of = ROAD_STRAIGHT;
    else              kind_of = ROAD_LOST;
  endfunction

  function automatic logic [7:0] dflt(input logic [7:0] v, input logic [7:0] d);
    dflt = (v == 8'd0) ? d : v;
  endfunction

endpackage

`default_nettype wire

FILE: src/ljc_path_decode.sv
// Frame decoder: masks the sensor word, forms left/forward/right paths from
// the configured groups and counts active sensors. Depends on ljc_pkg.
`default_nettype none

module ljc_path_decode import ljc_pkg::*; #(
  parameter int unsigned SensorCount = 8
) (
  input  wire logic [7:0] sensor_mask_i,
  input  wire cfg_t       cfg_i,
  output frame_info_t     info_o
);

  localparam logic [7:0] KeepMask = 8'((16'd1 << SensorCount) - 16'd1);

  logic [7:0] mask;
  logic [3:0] ones;

  assign mask = sensor_mask_i & KeepMask;

  // Count active sensors
  always_comb begin
    ones = 4'd0;
    for (int i = 0; i < 8; i++) begin
      ones = ones + {3'd0, mask[i]};
    end
  end

  // Form paths; an empty side group always matches
  always_comb begin
    info_o.mask           = mask;
    info_o.ones           = ones;
    info_o.paths[P_LEFT]  = ((mask & cfg_i.left_group) == cfg_i.left_group);
    info_o.paths[P_FWD]   = ((mask & cfg_i.center_group) != 8'd0);
    info_o.paths[P_RIGHT] = ((mask & cfg_i.right_group) == cfg_i.right_group);
  end

endmodule

`default_nettype wire

FILE: src/ljc_tracker.sv
// Junction tracker: phase machine, evidence counters and event publishing.
// Holds all per-frame state; depends on ljc_pkg.
`default_nettype none

module ljc_tracker import ljc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire frame_info_t info_i,
  input  wire logic [31:0] frame_i,
  input  wire cfg_t        cfg_i,
  output result_t          result_o
);

  logic [3:0]  road_q, road_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] last_seen_q, last_seen_d;
  logic [2:0]  cpaths_q, cpaths_d;
  logic [7:0]  obs_q, obs_d;
  logic [7:0]  lev_q, lev_d;
  logic [7:0]  fev_q, fev_d;
  logic [7:0]  rev_q, rev_d;
  logic [7:0]  car_q, car_d;
  logic [7:0]  exit_run_q, exit_run_d;
  logic [7:0]  entry_q, entry_d;
  logic [7:0]  peak_q, peak_d;
  logic [3:0]  peak_cnt_q, peak_cnt_d;
  logic [31:0] first_q, first_d;
  logic [7:0]  rearm_q, rearm_d;
  logic [31:0] evcnt_q, evcnt_d;

  logic [7:0] exit_lim;
  logic [7:0] rearm_lim;
  logic [7:0] obs_lim;
  logic       side;
  logic       fwd;

  assign exit_lim  = dflt(cfg_i.exit_count, 8'd3);
  assign rearm_lim = dflt(cfg_i.rearm_limit, 8'd6);
  assign obs_lim   = dflt(cfg_i.observe_limit, 8'd24);
  assign side      = info_i.paths[P_LEFT] | info_i.paths[P_RIGHT];
  assign fwd       = info_i.paths[P_FWD];

  // Next state and result for one frame
  always_comb begin
    logic       run_obs;
    logic       pub;
    logic [3:0] pub_type;
    logic [3:0] side_kind;
    logic [7:0] rr;
    logic [9:0] bonus;
    logic [9:0] conf;

    road_d     = road_q;
    phase_d    = phase_q;
    last_seen_d = last_seen_q;
    cpaths_d   = cpaths_q;
    obs_d      = obs_q;
    lev_d      = lev_q;
    fev_d      = fev_q;
    rev_d      = rev_q;
    car_d      = car_q;
    exit_run_d = exit_run_q;
    entry_d    = entry_q;
    peak_d     = peak_q;
    peak_cnt_d = peak_cnt_q;
    first_d    = first_q;
    rearm_d    = rearm_q;
    evcnt_d    = evcnt_q;
    run_obs    = 1'b0;
    pub        = 1'b0;
    pub_type   = ROAD_UNKNOWN;
    side_kind  = ROAD_UNKNOWN;
    rr         = 8'd0;
    bonus      = 10'd0;
    conf       = 10'd0;

    if (step_i && (cfg_i.confirm_count != 8'd0) && (frame_i != last_seen_q)) begin
      last_seen_d = frame_i;
      unique case (phase_q)
        PH_LATCHED: begin
          if (!side && fwd) begin
            rr = (rearm_q < rearm_lim) ? rearm_q + 8'd1 : rearm_q;
            rearm_d = rr;
            if (rr >= rearm_lim) begin
              // Rearm: back to line following, drop the observation
              phase_d    = PH_NORMAL;
              road_d     = ROAD_STRAIGHT;
              rearm_d    = 8'd0;
              cpaths_d   = 3'd0;
              obs_d      = 8'd0;
              lev_d      = 8'd0;
              fev_d      = 8'd0;
              rev_d      = 8'd0;
              car_d      = 8'd0;
              exit_run_d = 8'd0;
              entry_d    = 8'd0;
              peak_d     = 8'd0;
              peak_cnt_d = 4'd0;
              first_d    = 32'd0;
            end
          end else begin
            rearm_d = 8'd0;
          end
        end
        PH_NORMAL: begin
          if (!side) begin
            road_d = fwd ? ROAD_STRAIGHT
                         : ((info_i.mask == 8'd0) ? ROAD_LOST : ROAD_UNKNOWN);
          end else begin
            // Open an observation with cleared counters
            run_obs    = 1'b1;
            phase_d    = PH_OBSERVING;
            cpaths_d   = 3'd0;
            obs_d      = 8'd0;
            lev_d      = 8'd0;
            fev_d      = 8'd0;
            rev_d      = 8'd0;
            car_d      = 8'd0;
            exit_run_d = 8'd0;
            entry_d    = info_i.mask;
            peak_d     = info_i.mask;
            peak_cnt_d = info_i.ones;
            first_d    = frame_i;
          end
        end
        PH_OBSERVING: begin
          run_obs = 1'b1;
        end
        default: begin
          run_obs = 1'b0;
        end
      endcase

      if (run_obs) begin
        // Gather evidence
        obs_d = sat_inc(obs_d);
        if (info_i.paths[P_LEFT])  lev_d = sat_inc(lev_d);
        if (info_i.paths[P_FWD])   fev_d = sat_inc(fev_d);
        if (info_i.paths[P_RIGHT]) rev_d = sat_inc(rev_d);
        if (lev_d >= cfg_i.confirm_count) cpaths_d[P_LEFT]  = 1'b1;
        if (fev_d >= cfg_i.confirm_count) cpaths_d[P_FWD]   = 1'b1;
        if (rev_d >= cfg_i.confirm_count) cpaths_d[P_RIGHT] = 1'b1;
        if (info_i.ones > peak_cnt_d) begin
          peak_cnt_d = info_i.ones;
          peak_d     = info_i.mask;
        end
        road_d = kind_of(info_i.paths);

        car_d = (side && !fwd) ? sat_inc(car_d) : 8'd0;
        side_kind = kind_of({cpaths_d[P_RIGHT], 1'b0, cpaths_d[P_LEFT]});

        if ((car_d >= cfg_i.confirm_count) &&
            ((side_kind == ROAD_LCORNER) || (side_kind == ROAD_RCORNER) ||
             (side_kind == ROAD_T))) begin
          // Corner or T: center gone long enough
          pub      = 1'b1;
          pub_type = side_kind;
        end else begin
          exit_run_d = !side ? sat_inc(exit_run_d) : 8'd0;
          if (exit_run_d >= exit_lim) begin
            if ((cpaths_d[P_LEFT] | cpaths_d[P_RIGHT]) == 1'b0) begin
              // No side path confirmed: abandon the observation
              phase_d    = PH_NORMAL;
              road_d     = fwd ? ROAD_STRAIGHT : ROAD_LOST;
              cpaths_d   = 3'd0;
              obs_d      = 8'd0;
              lev_d      = 8'd0;
              fev_d      = 8'd0;
              rev_d      = 8'd0;
              car_d      = 8'd0;
              exit_run_d = 8'd0;
              entry_d    = 8'd0;
              peak_d     = 8'd0;
              peak_cnt_d = 4'd0;
              first_d    = 32'd0;
            end else begin
              pub      = 1'b1;
              pub_type = kind_of({cpaths_d[P_RIGHT], fwd, cpaths_d[P_LEFT]});
            end
          end else if (obs_d >= obs_lim) begin
            pub      = 1'b1;
            pub_type = kind_of({cpaths_d[P_RIGHT], fwd, cpaths_d[P_LEFT]});
          end
        end
      end

      if (pub) begin
        evcnt_d = evcnt_q + 32'd1;
        if (evcnt_d == 32'd0) evcnt_d = 32'd1;
        road_d  = pub_type;
        phase_d = PH_LATCHED;
        rearm_d = 8'd0;
      end
    end

    // Confidence: base plus capped observation bonus, extra for corners and T
    bonus = (obs_d >= 8'd13) ? 10'd250 : 10'(obs_d[3:0]) * 10'd20;
    conf  = 10'd650 + bonus;
    if ((pub_type == ROAD_LCORNER) || (pub_type == ROAD_RCORNER) ||
        (pub_type == ROAD_T)) begin
      conf = conf + 10'd100;
    end
    if (conf > 10'd1000) conf = 10'd1000;

    result_o.road_type       = (cfg_i.confirm_count == 8'd0) ? ROAD_UNKNOWN : road_d;
    result_o.phase_now       = phase_d;
    result_o.event_published = pub;
    result_o.event_number       = pub ? evcnt_d : 32'd0;
    result_o.event_type         = pub ? pub_type : 4'd0;
    result_o.event_paths        = pub ? cpaths_d : 3'd0;
    result_o.event_confidence   = pub ? conf : 10'd0;
    result_o.entry_sensor_mask  = pub ? entry_d : 8'd0;
    result_o.peak_sensor_mask   = pub ? peak_d : 8'd0;
    result_o.exit_sensor_mask   = pub ? info_i.mask : 8'd0;
    result_o.first_frame_number = pub ? first_d : 32'd0;
    result_o.last_frame_number  = pub ? frame_i : 32'd0;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      road_q      <= ROAD_UNKNOWN;
      phase_q     <= PH_NORMAL;
      last_seen_q <= 32'd0;
      cpaths_q    <= 3'd0;
      obs_q       <= 8'd0;
      lev_q       <= 8'd0;
      fev_q       <= 8'd0;
      rev_q       <= 8'd0;
      car_q       <= 8'd0;
      exit_run_q  <= 8'd0;
      entry_q     <= 8'd0;
      peak_q      <= 8'd0;
      peak_cnt_q  <= 4'd0;
      first_q     <= 32'd0;
      rearm_q     <= 8'd0;
      evcnt_q     <= 32'd0;
    end else begin
      road_q      <= road_d;
      phase_q     <= phase_d;
      last_seen_q <= last_seen_d;
      cpaths_q    <= cpaths_d;
      obs_q       <= obs_d;
      lev_q       <= lev_d;
      fev_q       <= fev_d;
      rev_q       <= rev_d;
      car_q       <= car_d;
      exit_run_q  <= exit_run_d;
      entry_q     <= entry_d;
      peak_q      <= peak_d;
      peak_cnt_q  <= peak_cnt_d;
      first_q     <= first_d;
      rearm_q     <= rearm_d;
      evcnt_q     <= evcnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/line_junction_classifier.sv
// Top level of the line junction classifier: stream ports, configuration
// registers, input and result registers. Uses ljc_pkg, ljc_path_decode and
// ljc_tracker.
//
// One request is one sensor frame; one result leaves for every frame taken.
// A frame is registered on entry, decoded and classified from the input
// register and written to the result register; a new frame is taken every
// cycle while the result side keeps up. Throughput is set by the result
// register: when it holds a result that is not taken, the input register
// holds too, and while it is full s_axis_tready drops. Configuration
// writes act at once and are meant for an idle block. Only the low
// SENSOR_COUNT bits of the sensor mask are used.
`default_nettype none

module line_junction_classifier import ljc_pkg::*; #(
  parameter int unsigned SENSOR_COUNT = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // fields from bit 0: sensor_mask[7:0], frame_number[39:8]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // fields from bit 0: road_type[3:0], phase_now[5:4], event_number[37:6],
  // event_type[41:38], event_paths[44:42], event_confidence[54:45],
  // entry_sensor_mask[62:55], peak_sensor_mask[70:63],
  // exit_sensor_mask[78:71], first_frame_number[110:79],
  // last_frame_number[142:111], zero pad[143]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // fields from bit 0: event_published
  output logic                       m_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_index_i,
  input  wire logic [7:0]            cfg_data_i
);

  cfg_t        cfg_q;
  logic        in_valid_q;
  logic [7:0]  in_mask_q;
  logic [31:0] in_frame_q;
  logic        out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic        out_user_q;
  logic        advance;
  logic        step;
  frame_info_t info;
  result_t     result;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_group    <= 8'd3;
      cfg_q.center_group  <= 8'd24;
      cfg_q.right_group   <= 8'd192;
      cfg_q.confirm_count <= 8'd2;
      cfg_q.exit_count    <= 8'd3;
      cfg_q.rearm_limit   <= 8'd6;
      cfg_q.observe_limit <= 8'd24;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LEFT_MASK:   cfg_q.left_group    <= cfg_data_i;
        REG_CENTER_MASK: cfg_q.center_group  <= cfg_data_i;
        REG_RIGHT_MASK:  cfg_q.right_group   <= cfg_data_i;
        REG_CONFIRM:     cfg_q.confirm_count <= cfg_data_i;
        REG_EXIT:        cfg_q.exit_count    <= cfg_data_i;
        REG_REARM:       cfg_q.rearm_limit   <= cfg_data_i;
        REG_OBSERVE:     cfg_q.observe_limit <= cfg_data_i;
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  // Input register: take a request whenever the stage drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mask_q  <= s_axis_tdata[7:0];
      in_frame_q <= s_axis_tdata[39:8];
    end
  end

  ljc_path_decode #(
    .SensorCount(SENSOR_COUNT)
  ) u_decode (
    .sensor_mask_i(in_mask_q),
    .cfg_i        (cfg_q),
    .info_o       (info)
  );

  ljc_tracker u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .info_i  (info),
    .frame_i (in_frame_q),
    .cfg_i   (cfg_q),
    .result_o(result)
  );

  // Pack the result fields
  assign out_data_d = {1'b0,
                       result.last_frame_number,
                       result.first_frame_number,
                       result.exit_sensor_mask,
                       result.peak_sensor_mask,
                       result.entry_sensor_mask,
                       result.event_confidence,
                       result.event_paths,
                       result.event_type,
                       result.event_number,
                       result.phase_now,
                       result.road_type};

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= out_data_d;
      out_user_q <= result.event_published;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire
